FILE: rtl/core/lcd_nibble_write_sequencer_core_macros.svh
// Assertion macros shared by the nibble write sequencer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LNWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LNWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/lnws_pkg.sv
// Shared types and constants for the nibble write sequencer.
// No dependencies; imported by every module of the block.
package lnws_pkg;

   localparam int CFG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int BYTE_WIDTH      = 8;
   localparam int NIBBLE_WIDTH    = 4;

   localparam logic [CFG_WIDTH-1:0] STROBE_TICKS_RESET = 16'd10;
   localparam logic [CFG_WIDTH-1:0] LONG_WAIT_RESET    = 16'd3000;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STROBE_TICKS    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_WAIT_TICKS = 2'd1;

   typedef enum logic {
      ITEM_TICK  = 1'b0,
      ITEM_WRITE = 1'b1
   } item_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HIGH,
      PH_LOW1,
      PH_LOWN,
      PH_LOW2,
      PH_LONG
   } phase_type;

   typedef struct packed {
      item_kind_type          kind;
      logic                   reg_select;
      logic [BYTE_WIDTH-1:0]  value;
   } item_type;

   // Front-to-back queue head
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic                    rs_pin;
      logic                    strobe_pin;
      logic [NIBBLE_WIDTH-1:0] data_nibble;
      logic                    busy_res;
      logic                    rejected;
   } result_type;

   // Clear, home and command three take the long wait
   function automatic logic needs_long_wait(input logic sel, input logic [BYTE_WIDTH-1:0] b);
      return (sel == 1'b0) && (b[BYTE_WIDTH-1:2] == '0) && (b[1:0] != 2'b00);
   endfunction

endpackage

FILE: rtl/core/lcd_nibble_write_sequencer_core.sv
// A request is registered in the front queue and its result in the result queue.
// Throughput: one item per cycle while the result queue has room, set by the
// single-step sequencer in the back end. Queues of two entries on each side
// keep full-rate flow through stalls.
// Reset: synchronous, active high; strobe_ticks 10, long_wait_ticks 3000,
// sequencer idle with the strobe line high, both queues empty.
module lcd_nibble_write_sequencer_core
   import lnws_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_action,
   input  logic                       req_reg_select,
   input  logic [BYTE_WIDTH-1:0]      req_value,
   output logic                       empty,
   input  logic                       pop,
   output logic                       rsp_rs_pin,
   output logic                       rsp_strobe_pin,
   output logic [NIBBLE_WIDTH-1:0]    rsp_data_nibble,
   output logic                       rsp_busy_res,
   output logic                       rsp_rejected,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data
);

   queue_head_type head;
   logic           head_take;
   result_type     rsp;

   lnws_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_action     (req_action),
      .req_reg_select (req_reg_select),
      .req_value      (req_value),
      .head           (head),
      .head_take      (head_take)
   );

   lnws_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_take      (head_take),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .empty          (empty),
      .pop            (pop),
      .rsp            (rsp)
   );

   assign rsp_rs_pin      = rsp.rs_pin;
   assign rsp_strobe_pin  = rsp.strobe_pin;
   assign rsp_data_nibble = rsp.data_nibble;
   assign rsp_busy_res    = rsp.busy_res;
   assign rsp_rejected    = rsp.rejected;

endmodule

FILE: rtl/core/lnws_front.sv
// Front end: accepts request items, classifies them and queues them.
// Depends on lnws_pkg.
module lnws_front
   import lnws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_action,
   input  logic                  req_reg_select,
   input  logic [BYTE_WIDTH-1:0] req_value,
   output queue_head_type        head,
   input  logic                  head_take
);

   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   item_type   slot_ff [2];
   item_type   classified;
   logic       push_fire;
   logic       pop_fire;

   // Classify: drop the payload of tick items
   always_comb begin
      classified.kind       = req_action ? ITEM_WRITE : ITEM_TICK;
      classified.reg_select = req_action ? req_reg_select : 1'b0;
      classified.value      = req_action ? req_value : '0;
   end

   assign full      = (cnt_ff == 2'd2);
   assign push_fire = push && !full;
   assign pop_fire  = head.valid && head_take;

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push_fire ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_fire ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_fire && !pop_fire) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_fire && !push_fire) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Store the transfer
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: rtl/core/lnws_back.sv
// Back end: strobe sequencer, configuration registers and result queue.
// Depends on lnws_pkg and the shared assertion macros.
`include "lcd_nibble_write_sequencer_core_macros.svh"
module lnws_back
   import lnws_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  queue_head_type             head,
   output logic                       head_take,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data,
   output logic                       empty,
   input  logic                       pop,
   output result_type                 rsp
);

   logic [CFG_WIDTH-1:0]    strobe_ticks_ff;
   logic [CFG_WIDTH-1:0]    long_wait_ff;
   phase_type               phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0]  cnt_dec;
   logic [COUNT_WIDTH-1:0]  strobe_load;
   logic [COUNT_WIDTH-1:0]  long_load;
   logic [BYTE_WIDTH-1:0]   byte_ff, byte_in;
   logic                    sel_ff, sel_in;
   logic                    rs_ff, rs_in;
   logic                    strobe_ff, strobe_in;
   logic [NIBBLE_WIDTH-1:0] data_ff, data_in;
   logic                    rej;
   logic                    busy;
   logic                    is_write;
   logic                    start;
   logic                    tick;
   logic                    step;
   result_type              result;

   result_type              out_ff [2];
   logic [1:0]              out_cnt_ff, out_cnt_in;
   logic                    out_wr_ff, out_rd_ff;
   logic                    out_room;
   logic                    pop_fire;

   // Saturate a loaded wait to the counter range
   function automatic logic [COUNT_WIDTH-1:0] count_load(input logic [CFG_WIDTH-1:0] v);
      if ((v >> COUNT_WIDTH) != '0) begin
         return '1;
      end
      return COUNT_WIDTH'(v);
   endfunction

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ticks_ff <= STROBE_TICKS_RESET;
         long_wait_ff    <= LONG_WAIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_STROBE_TICKS:    strobe_ticks_ff <= csr_write_data;
            CSR_LONG_WAIT_TICKS: long_wait_ff    <= csr_write_data;
            default:             ;
         endcase
      end
   end

   // Take an item whenever the result queue has room
   assign pop_fire  = pop && !empty;
   assign out_room  = (out_cnt_ff != 2'd2) || pop_fire;
   assign head_take = out_room;

   assign busy        = (phase_ff != PH_IDLE);
   assign is_write    = (head.item.kind == ITEM_WRITE);
   assign start       = head.valid && out_room && is_write && !busy;
   assign tick        = head.valid && out_room && !is_write && busy;
   assign cnt_dec     = (cnt_ff != '0) ? cnt_ff - COUNT_WIDTH'(1) : '0;
   assign step        = tick && (cnt_dec == '0);
   assign strobe_load = count_load(strobe_ticks_ff);
   assign long_load   = count_load(long_wait_ff);

   // Next state: phase and wait counter
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         phase_in = PH_HIGH;
         cnt_in   = strobe_load;
      end else if (tick) begin
         cnt_in = cnt_dec;
         if (step) begin
            unique case (phase_ff)
               PH_HIGH: begin
                  phase_in = PH_LOW1;
                  cnt_in   = strobe_load;
               end
               PH_LOW1: begin
                  phase_in = PH_LOWN;
                  cnt_in   = strobe_load;
               end
               PH_LOWN: begin
                  phase_in = PH_LOW2;
                  cnt_in   = strobe_load;
               end
               PH_LOW2: begin
                  if (needs_long_wait(sel_ff, byte_ff)) begin
                     phase_in = PH_LONG;
                     cnt_in   = long_load;
                  end else begin
                     phase_in = PH_IDLE;
                     cnt_in   = '0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  cnt_in   = '0;
               end
            endcase
         end
      end
   end

   // Outputs: pin levels, held byte and reject flag
   always_comb begin
      rs_in     = rs_ff;
      strobe_in = strobe_ff;
      data_in   = data_ff;
      byte_in   = byte_ff;
      sel_in    = sel_ff;
      rej       = head.valid && is_write && busy;
      if (start) begin
         sel_in    = head.item.reg_select;
         byte_in   = head.item.value;
         rs_in     = head.item.reg_select;
         strobe_in = 1'b1;
         data_in   = head.item.value[BYTE_WIDTH-1:NIBBLE_WIDTH];
      end else if (step) begin
         unique case (phase_ff)
            PH_HIGH, PH_LOWN: strobe_in = 1'b0;
            PH_LOW1: begin
               strobe_in = 1'b1;
               data_in   = byte_ff[NIBBLE_WIDTH-1:0];
            end
            PH_LOW2: strobe_in = 1'b1;
            default: ;
         endcase
      end
      result.rs_pin      = rs_in;
      result.strobe_pin  = strobe_in;
      result.data_nibble = data_in;
      result.busy_res    = (phase_in != PH_IDLE);
      result.rejected    = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= '0;
         byte_ff   <= '0;
         sel_ff    <= 1'b0;
         rs_ff     <= 1'b0;
         strobe_ff <= 1'b1;
         data_ff   <= '0;
      end else if (head.valid && out_room) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         byte_ff   <= byte_in;
         sel_ff    <= sel_in;
         rs_ff     <= rs_in;
         strobe_ff <= strobe_in;
         data_ff   <= data_in;
      end
   end

   // Result queue: two entries so the sequencer runs while a result waits
   assign empty = (out_cnt_ff == 2'd0);
   assign rsp   = out_ff[out_rd_ff];

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (head.valid && out_room && !pop_fire) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (pop_fire && !(head.valid && out_room)) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         if (head.valid && out_room) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (pop_fire) begin
            out_rd_ff <= ~out_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head.valid && out_room) begin
         out_ff[out_wr_ff] <= result;
      end
   end

   `LNWS_ASSERT_NOW(a_idle_no_count, clock, reset, phase_ff == PH_IDLE, cnt_ff == '0, "count left over in idle")
   `LNWS_ASSERT_NOW(a_strobe_low_phase, clock, reset, !strobe_ff, phase_ff == PH_LOW1 || phase_ff == PH_LOW2, "strobe low outside a low phase")
   `LNWS_ASSERT_NOW(a_out_bound, clock, reset, 1'b1, out_cnt_ff <= 2'd2, "result queue overflow")
   `LNWS_ASSERT_NOW(a_reject_busy, clock, reset, head.valid && out_room && rej, busy && result.busy_res, "reject while idle")
   `LNWS_ASSERT_NEXT(a_start_high, clock, reset, start, phase_ff == PH_HIGH && strobe_ff, "write did not start sequence")

endmodule
